// ----- hw/rtl/aus_pkg.sv -----
// Shared types, constants and helpers for the Annex B access-unit splitter.
package aus_pkg;

  // Delay line and result queue sizes
  localparam int DEPTH        = 5;
  localparam int MAX_PUSH     = DEPTH + 1;
  localparam int QUEUE_DEPTH  = MAX_PUSH + 1;
  localparam int WIN_IDX_W    = $clog2(DEPTH);
  localparam int FILL_W       = $clog2(DEPTH + 1);
  localparam int PUSH_IDX_W   = $clog2(MAX_PUSH);
  localparam int PUSH_CNT_W   = $clog2(MAX_PUSH + 1);
  localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic REG_CODEC_MODE = 1'b0;

  // Codec selection
  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  // Frame kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_INTER = 2'd1;
  localparam logic [1:0] KIND_INTRA = 2'd2;

  // Start code bytes and lengths
  localparam logic [7:0] SC_ZERO  = 8'h00;
  localparam logic [7:0] SC_ONE   = 8'h01;
  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_SHORT = 3'd3;
  localparam logic [2:0] CODE_LONG  = 3'd4;

  // H.264 NAL types
  localparam logic [4:0] H264_SLICE = 5'h01;
  localparam logic [4:0] H264_IDR   = 5'h05;
  localparam logic [4:0] H264_SEI   = 5'h06;
  localparam logic [4:0] H264_SPS   = 5'h07;
  localparam logic [4:0] H264_PPS   = 5'h08;

  // H.265 NAL type ranges
  localparam logic [5:0] H265_VCL_HI   = 6'd31;
  localparam logic [5:0] H265_INTER_LO = 6'd1;
  localparam logic [5:0] H265_INTER_HI = 6'd9;
  localparam logic [5:0] H265_INTRA_LO = 6'd16;
  localparam logic [5:0] H265_INTRA_HI = 6'd23;
  localparam logic [5:0] H265_PARAM_LO = 6'd32;
  localparam logic [5:0] H265_PARAM_HI = 6'd39;
  localparam logic [5:0] H265_TYPE0    = 6'd0;

  // Boundary mark carried alongside a byte in the delay line
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       long_code;
  } mark_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic [1:0] ended_kind;
    logic [2:0] code_length;
    logic       stream_done;
  } result_t;

  // Results produced by one accepted input item
  typedef struct packed {
    logic [PUSH_CNT_W-1:0]     count;
    result_t [MAX_PUSH-1:0]    entry;
  } push_t;

  // Build a result item from a byte and its mark
  function automatic result_t make_result(logic [7:0] b, mark_t m, logic done,
                                          logic [1:0] final_kind);
    result_t r;
    r.out_byte    = b;
    r.frame_start = m.valid;
    r.ended_kind  = m.valid ? m.kind : KIND_NONE;
    r.code_length = m.valid ? (m.long_code ? CODE_LONG : CODE_SHORT) : CODE_NONE;
    r.stream_done = done;
    if (done) begin
      r.ended_kind = final_kind;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/aus_if.sv -----
// Valid/ready channel interfaces for stream input and result output.
interface aus_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface aus_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_start;
  logic [1:0] ended_kind;
  logic [2:0] code_length;
  logic       stream_done;

  modport source (output valid, output out_byte, output frame_start, output ended_kind,
                  output code_length, output stream_done, input ready);
  modport sink   (input valid, input out_byte, input frame_start, input ended_kind,
                  input code_length, input stream_done, output ready);
endinterface

// ----- hw/rtl/aus_cfg.sv -----
// APB-style configuration register block (codec mode).
module aus_cfg
  import aus_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  codec_mode
);

  logic reg_sel;

  // Word-aligned decode: bit 2 picks the register index
  assign reg_sel = (paddr[2] == REG_CODEC_MODE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= CODEC_H264;
    end else if (psel && penable && pwrite && reg_sel) begin
      codec_mode <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, codec_mode};
    end
  end

endmodule

// ----- hw/rtl/aus_window.sv -----
// Five-byte delay line with start-code detection and NAL classification.
module aus_window
  import aus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] stream_byte,
  input  logic       end_of_stream,
  input  logic       codec_mode,
  output push_t      push
);

  logic [7:0]        win      [DEPTH];
  mark_t             marks    [DEPTH];
  logic [FILL_W-1:0] fill;
  logic              vcl_seen;
  logic [1:0]        cur_kind;

  logic [7:0]        win_next   [DEPTH];
  mark_t             marks_next [DEPTH];
  logic [FILL_W-1:0] fill_next;
  logic              vcl_seen_next;
  logic [1:0]        cur_kind_next;

  logic              full;
  logic              detect;
  logic              long_code;
  logic [4:0]        t264;
  logic [5:0]        t265;
  logic              is_param;
  logic              is_vcl;
  logic              has_kind;
  logic [1:0]        nal_kind;
  logic              boundary;
  mark_t             new_mark;

  assign full = (fill == FILL_W'(DEPTH));
  assign t264 = stream_byte[4:0];
  assign t265 = stream_byte[6:1];

  // NAL header typing
  always_comb begin
    is_param = 1'b0;
    is_vcl   = 1'b0;
    has_kind = 1'b0;
    nal_kind = KIND_NONE;
    if (codec_mode == CODEC_H264) begin
      case (t264)
        H264_SLICE: begin
          is_vcl   = 1'b1;
          has_kind = 1'b1;
          nal_kind = KIND_INTER;
        end
        H264_IDR: begin
          is_vcl   = 1'b1;
          has_kind = 1'b1;
          nal_kind = KIND_INTRA;
        end
        H264_SEI, H264_SPS, H264_PPS: begin
          is_param = 1'b1;
        end
        default: ;
      endcase
    end else begin
      is_param = (t265 inside {[H265_PARAM_LO:H265_PARAM_HI]});
      is_vcl   = (t265 <= H265_VCL_HI);
      if (t265 inside {[H265_INTER_LO:H265_INTER_HI]}) begin
        has_kind = 1'b1;
        nal_kind = KIND_INTER;
      end else if (t265 inside {[H265_INTRA_LO:H265_INTRA_HI]}) begin
        has_kind = 1'b1;
        nal_kind = KIND_INTRA;
      end else if (t265 == H265_TYPE0) begin
        has_kind = 1'b1;
        nal_kind = KIND_NONE;
      end
    end
  end

  // Shift, detect the start code, and update frame tracking
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      win_next[i]   = win[i+1];
      marks_next[i] = marks[i+1];
    end
    win_next[DEPTH-1]   = stream_byte;
    marks_next[DEPTH-1] = '0;
    fill_next = full ? fill : fill + FILL_W'(1);

    // 00 00 01 followed by the header byte just taken in
    detect = (fill_next >= FILL_W'(DEPTH - 1)) && (win_next[1] == SC_ZERO) &&
             (win_next[2] == SC_ZERO) && (win_next[3] == SC_ONE);
    long_code = (fill_next == FILL_W'(DEPTH)) && (win_next[0] == SC_ZERO);

    vcl_seen_next = vcl_seen;
    cur_kind_next = cur_kind;
    boundary      = detect && (is_param || is_vcl) && vcl_seen;
    new_mark.valid     = 1'b1;
    new_mark.kind      = cur_kind;
    new_mark.long_code = long_code;
    if (boundary) begin
      vcl_seen_next = 1'b0;
      cur_kind_next = KIND_NONE;
      if (long_code) begin
        marks_next[0] = new_mark;
      end else begin
        marks_next[1] = new_mark;
      end
    end
    if (detect && is_vcl) begin
      vcl_seen_next = 1'b1;
      if (has_kind) begin
        cur_kind_next = nal_kind;
      end
    end
  end

  // Results caused by this item: the byte leaving the line, plus a drain on end of stream
  always_comb begin
    int idx;
    int cnt;
    push = '0;
    cnt  = 0;
    idx  = 0;
    if (accept) begin
      if (end_of_stream) begin
        cnt = int'(fill_next) + (full ? 1 : 0);
      end else begin
        cnt = full ? 1 : 0;
      end
      push.count = PUSH_CNT_W'(cnt);
      for (int k = 0; k < MAX_PUSH; k++) begin
        if (full) begin
          if (k == 0) begin
            push.entry[k] = make_result(win[0], marks[0], 1'b0, KIND_NONE);
          end else begin
            push.entry[k] = make_result(win_next[k-1], marks_next[k-1],
                                        (k == cnt - 1), cur_kind_next);
          end
        end else begin
          idx = DEPTH - int'(fill_next) + k;
          if (idx < DEPTH) begin
            push.entry[k] = make_result(win_next[idx[WIN_IDX_W-1:0]],
                                        marks_next[idx[WIN_IDX_W-1:0]],
                                        (k == cnt - 1), cur_kind_next);
          end
        end
      end
    end
  end

  // Control state: end of stream returns everything to the empty state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      vcl_seen <= 1'b0;
      cur_kind <= KIND_NONE;
      for (int i = 0; i < DEPTH; i++) begin
        marks[i] <= '0;
      end
    end else if (accept) begin
      if (end_of_stream) begin
        fill     <= '0;
        vcl_seen <= 1'b0;
        cur_kind <= KIND_NONE;
        for (int i = 0; i < DEPTH; i++) begin
          marks[i] <= '0;
        end
      end else begin
        fill     <= fill_next;
        vcl_seen <= vcl_seen_next;
        cur_kind <= cur_kind_next;
        for (int i = 0; i < DEPTH; i++) begin
          marks[i] <= marks_next[i];
        end
      end
    end
  end

  // Byte line
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DEPTH; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// ----- hw/rtl/aus_result_queue.sv -----
// Result queue: takes up to six items per cycle, hands out one per handshake.
module aus_result_queue
  import aus_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output logic         can_take,
  aus_result_if.source result
);

  result_t           q      [QUEUE_DEPTH];
  result_t           q_next [QUEUE_DEPTH];
  logic [QCNT_W-1:0] qn;
  logic [QCNT_W-1:0] qn_next;
  logic [QCNT_W-1:0] base;
  logic              pop;

  assign pop      = (qn != '0) && result.ready;
  assign base     = qn - QCNT_W'(pop);
  assign can_take = (qn <= QCNT_W'(1));

  // Shift out the taken item and append the new ones behind what remains
  always_comb begin
    int off;
    off = 0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (pop && (j < QUEUE_DEPTH - 1)) begin
        q_next[j] = q[j+1];
      end else begin
        q_next[j] = q[j];
      end
      if (j >= int'(base)) begin
        off = j - int'(base);
        if (off < int'(push.count)) begin
          q_next[j] = push.entry[off[PUSH_IDX_W-1:0]];
        end
      end
    end
    qn_next = QCNT_W'({1'b0, base} + {1'b0, push.count});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qn <= '0;
    end else begin
      qn <= qn_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      q[j] <= q_next[j];
    end
  end

  // Head of queue drives the output channel
  assign result.valid       = (qn != '0);
  assign result.out_byte    = q[0].out_byte;
  assign result.frame_start = q[0].frame_start;
  assign result.ended_kind  = q[0].ended_kind;
  assign result.code_length = q[0].code_length;
  assign result.stream_done = q[0].stream_done;

endmodule

// ----- hw/rtl/annexb_access_unit_splitter.sv -----
// Annex B access-unit splitter: one stream byte in per cycle while ready is
// high; each byte leaves five items later with frame-boundary marks on the
// first start-code byte of each new frame. The sustained rate is one item per
// cycle while results are taken, with the window update combinational between
// the delay-line registers and the result queue. An end-of-stream item
// releases up to six results, which leave one per cycle while the receiver is
// ready; input is held off while more than one result is queued. There is no
// clearing pass after reset. codec_mode sits at byte address 0.
module annexb_access_unit_splitter
  import aus_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  aus_stream_if.sink            stream,
  aus_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic  codec_mode;
  logic  can_take;
  logic  accept;
  push_t push;

  assign stream.ready = can_take;
  assign accept       = stream.valid && can_take;

  aus_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .codec_mode (codec_mode)
  );

  aus_window u_window (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .stream_byte   (stream.stream_byte),
    .end_of_stream (stream.end_of_stream),
    .codec_mode    (codec_mode),
    .push          (push)
  );

  aus_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .can_take (can_take),
    .result   (result)
  );

endmodule

// ----- hw/rtl/aus_checker.sv -----
// Port-level checks for the splitter, bound to the top level.
module aus_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_eos,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_done
);

  // Leaving reset, nothing is queued
  assert property (@(posedge clk) $fell(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // An end-of-stream item always releases at least one result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eos |=> out_valid)
    else $error("end of stream did not release a result");

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its byte and done flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_done))
    else $error("result payload changed while stalled");

endmodule

bind annexb_access_unit_splitter aus_checker u_aus_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stream.valid),
  .in_ready  (stream.ready),
  .in_eos    (stream.end_of_stream),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .out_done  (result.stream_done)
);

// ----- sim/annexb_access_unit_splitter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Annex B access-unit splitter: byte streams in, marked bytes out.
module annexb_access_unit_splitter_tb;
  import aus_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 40;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CODEC_MODE = CFG_ADDR_W'(4 * REG_CODEC_MODE);
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE      = CFG_ADDR_W'(4);

  typedef logic [7:0] byte_list_t[$];

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  aus_stream_if stream_ch ();
  aus_result_if result_ch ();

  annexb_access_unit_splitter uut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted splitter state
  logic       codec;
  logic [7:0] win_byte [DEPTH];
  mark_t      win_mark [DEPTH];
  int         win_fill;
  logic       vcl_seen;
  logic [1:0] cur_kind;
  result_t    due_bytes[$];

  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t outgoing(input logic [7:0] b, input mark_t m, input logic done,
                                       input logic [1:0] final_kind);
    result_t r;
    r.out_byte    = b;
    r.frame_start = m.valid;
    r.ended_kind  = m.valid ? m.kind : KIND_NONE;
    r.code_length = !m.valid ? CODE_NONE : (m.long_code ? CODE_LONG : CODE_SHORT);
    r.stream_done = done;
    if (done) r.ended_kind = final_kind;
    return r;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < DEPTH; i++) begin
      win_byte[i] = SC_ZERO;
      win_mark[i] = '0;
    end
    win_fill = 0;
    vcl_seen = 1'b0;
    cur_kind = KIND_NONE;
  endfunction

  // Advance the predicted delay line by one accepted byte
  function automatic void shift_in_byte(input logic [7:0] b, input logic eos);
    mark_t      m;
    logic       long_sc;
    logic       is_param;
    logic       is_vcl;
    logic       has_kind;
    logic [1:0] nal_kind;
    logic [1:0] last_kind;
    logic [4:0] t5;
    logic [5:0] t6;
    m = '0;
    if (win_fill == DEPTH)
      due_bytes.push_back(outgoing(win_byte[0], win_mark[0], 1'b0, KIND_NONE));
    for (int i = 0; i < DEPTH - 1; i++) begin
      win_byte[i] = win_byte[i + 1];
      win_mark[i] = win_mark[i + 1];
    end
    win_byte[DEPTH - 1] = b;
    win_mark[DEPTH - 1] = '0;
    if (win_fill < DEPTH) win_fill++;

    // Start code in the window, b is the NAL header
    if (win_fill >= 4 && win_byte[1] == SC_ZERO && win_byte[2] == SC_ZERO &&
        win_byte[3] == SC_ONE) begin
      long_sc  = (win_fill == DEPTH && win_byte[0] == SC_ZERO);
      has_kind = 1'b0;
      nal_kind = KIND_NONE;
      if (codec == CODEC_H264) begin
        t5       = b[4:0];
        is_param = (t5 == H264_SEI || t5 == H264_SPS || t5 == H264_PPS);
        is_vcl   = (t5 == H264_SLICE || t5 == H264_IDR);
        has_kind = is_vcl;
        nal_kind = (t5 == H264_SLICE) ? KIND_INTER : KIND_INTRA;
      end else begin
        t6       = b[6:1];
        is_param = (t6 >= H265_PARAM_LO && t6 <= H265_PARAM_HI);
        is_vcl   = (t6 <= H265_VCL_HI);
        if (t6 >= H265_INTER_LO && t6 <= H265_INTER_HI) begin
          has_kind = 1'b1;
          nal_kind = KIND_INTER;
        end else if (t6 >= H265_INTRA_LO && t6 <= H265_INTRA_HI) begin
          has_kind = 1'b1;
          nal_kind = KIND_INTRA;
        end else if (t6 == H265_TYPE0) begin
          has_kind = 1'b1;
          nal_kind = KIND_NONE;
        end
      end
      if ((is_param || is_vcl) && vcl_seen) begin
        m.valid     = 1'b1;
        m.kind      = cur_kind;
        m.long_code = long_sc;
        vcl_seen    = 1'b0;
        cur_kind    = KIND_NONE;
      end
      if (is_vcl) begin
        vcl_seen = 1'b1;
        if (has_kind) cur_kind = nal_kind;
      end
      if (m.valid) win_mark[long_sc ? 0 : 1] = m;
    end

    // End of stream drains everything held
    if (eos) begin
      last_kind = cur_kind;
      for (int i = DEPTH - win_fill; i < DEPTH; i++)
        due_bytes.push_back(outgoing(win_byte[i], win_mark[i], i == DEPTH - 1, last_kind));
      clear_window();
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Predict on accepted input, then check accepted output against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (stream_ch.valid && stream_ch.ready)
        shift_in_byte(stream_ch.stream_byte, stream_ch.end_of_stream);
      if (result_ch.valid && result_ch.ready) begin
        got.out_byte    = result_ch.out_byte;
        got.frame_start = result_ch.frame_start;
        got.ended_kind  = result_ch.ended_kind;
        got.code_length = result_ch.code_length;
        got.stream_done = result_ch.stream_done;
        if (due_bytes.size() == 0) begin
          flag_mismatch("unexpected item", got.out_byte, 0);
        end else begin
          want = due_bytes.pop_front();
          if (got.out_byte !== want.out_byte)
            flag_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.frame_start !== want.frame_start)
            flag_mismatch("frame_start", got.frame_start, want.frame_start);
          if (got.ended_kind !== want.ended_kind)
            flag_mismatch("ended_kind", got.ended_kind, want.ended_kind);
          if (got.code_length !== want.code_length)
            flag_mismatch("code_length", got.code_length, want.code_length);
          if (got.stream_done !== want.stream_done)
            flag_mismatch("stream_done", got.stream_done, want.stream_done);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no item moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog expired, %0d items outstanding", $time, due_bytes.size());
    $display("annexb_access_unit_splitter_tb: errors");
    $finish;
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_CODEC_MODE) codec = data[0];
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_codec(input logic mode);
    cfg_write(ADDR_CODEC_MODE, {(CFG_DATA_W-1)'($urandom), mode});
  endtask

  // Send one byte and wait for it to be taken; maybe idle afterwards
  task automatic send_byte(input logic [7:0] b, input logic eos);
    stream_ch.valid         <= 1'b1;
    stream_ch.stream_byte   <= b;
    stream_ch.end_of_stream <= eos;
    do @(posedge clk); while (!stream_ch.ready);
    if ($urandom_range(99) < send_idle_pct) begin
      stream_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_bytes(input byte_list_t bytes, input logic eos_last);
    foreach (bytes[i]) send_byte(bytes[i], eos_last && i == bytes.size() - 1);
  endtask

  // Stop offering, let every expected item arrive, then let the block settle
  task automatic wait_idle();
    stream_ch.valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_header();
    logic [4:0] t5;
    logic [5:0] t6;
    int         pick;
    pick = $urandom_range(7);
    if (codec == CODEC_H264) begin
      case (pick)
        0, 1, 2: t5 = H264_SLICE;
        3:       t5 = H264_IDR;
        4:       t5 = H264_SEI;
        5:       t5 = H264_SPS;
        6:       t5 = H264_PPS;
        default: t5 = 5'($urandom_range(31));
      endcase
      return {3'($urandom_range(7)), t5};
    end
    case (pick)
      0, 1:    t6 = 6'($urandom_range(H265_INTER_HI, H265_INTER_LO));
      2:       t6 = 6'($urandom_range(H265_INTRA_HI, H265_INTRA_LO));
      3:       t6 = H265_TYPE0;
      4:       t6 = $urandom_range(1) ? 6'($urandom_range(15, 10)) : 6'($urandom_range(31, 24));
      5, 6:    t6 = 6'($urandom_range(H265_PARAM_HI, H265_PARAM_LO));
      default: t6 = 6'($urandom_range(63));
    endcase
    return {1'($urandom_range(1)), t6, 1'($urandom_range(1))};
  endfunction

  // One NAL: start code, header, short payload
  task automatic send_nal(input logic long_sc, input int payload_len, input logic eos_last);
    if (long_sc) send_byte(SC_ZERO, 1'b0);
    send_byte(SC_ZERO, 1'b0);
    send_byte(SC_ZERO, 1'b0);
    send_byte(SC_ONE, 1'b0);
    send_byte(random_header(), eos_last && payload_len == 0);
    for (int i = 0; i < payload_len; i++)
      send_byte(8'($urandom), eos_last && i == payload_len - 1);
  endtask

  task automatic test_h264_frames();
    byte_list_t bytes;
    send_idle_pct = 34;
    recv_idle_pct = 52;
    set_codec(CODEC_H264);
    // IDR first (no mark), slice after long code, SEI after one VCL, then a bare start code
    bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41,
             8'h00, 8'h00, 8'h01, 8'h06, 8'hFF, 8'h00, 8'h00, 8'h01};
    send_bytes(bytes, 1'b1);
    // Stream shorter than the window
    send_byte(8'h7F, 1'b1);
    wait_idle();
  endtask

  task automatic test_h265_frames();
    byte_list_t bytes;
    set_codec(CODEC_H265);
    // Intra, then type 0 (boundary), then SEI after one VCL (boundary, kind none)
    bytes = {8'h00, 8'h00, 8'h01, 8'h26, 8'h00, 8'h00, 8'h01, 8'h00,
             8'h00, 8'h00, 8'h01, 8'h4E, 8'h80};
    send_bytes(bytes, 1'b1);
    wait_idle();
  endtask

  // A write to an unmapped index must leave codec_mode alone
  task automatic test_register_index();
    logic [CFG_DATA_W-1:0] rd;
    cfg_write(ADDR_SPARE, {(CFG_DATA_W-1)'($urandom), ~codec});
    cfg_read(ADDR_CODEC_MODE, rd);
    if (rd[0] !== codec) flag_mismatch("codec_mode readback", rd[0], codec);
  endtask

  // Mostly well-formed NALs with random content, some noise and broken start codes
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input logic mode,
                                     input int n_items);
    int sent;
    int plen;
    int r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_codec(mode);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        plen = $urandom_range(4);
        send_nal(1'($urandom_range(1)), plen, $urandom_range(19) == 0);
        sent += 5 + plen;
      end else if (r < 92) begin
        send_byte($urandom_range(2) == 0 ? SC_ZERO : 8'($urandom), 1'b0);
        sent++;
      end else begin
        send_byte(SC_ZERO, 1'b0);
        send_byte(SC_ZERO, 1'b0);
        send_byte(8'($urandom), 1'($urandom_range(1)));
        sent += 3;
      end
    end
    send_byte(8'($urandom), 1'b1);
    wait_idle();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_codec(CODEC_H264);
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_nal(1'($urandom_range(1)), 2, 1'b0);
    send_byte(8'($urandom), 1'b1);
    wait_idle();
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    codec          = CODEC_H264;
    clear_window();
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    stream_ch.valid         <= 1'b0;
    stream_ch.stream_byte   <= '0;
    stream_ch.end_of_stream <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_h264_frames();
    test_h265_frames();
    test_register_index();
    test_random_traffic(34, 52, CODEC_H264, 18);
    test_random_traffic(52, 34, CODEC_H265, 18);
    test_random_traffic(0, 0, 1'($urandom_range(1)), 18);
    test_backpressure();

    if (mismatch_count == 0 && due_bytes.size() == 0) begin
      $display("annexb_access_unit_splitter_tb: clean");
    end else begin
      $display("annexb_access_unit_splitter_tb: errors");
    end
    $finish;
  end

endmodule
